// ----- src/wdbm_pkg.sv -----
// shared widths, command codes and stage counts for the wavenumber bin multiplier
`timescale 1ns / 1ps

package wdbm_pkg;

  // field and register widths
  localparam int CMD_W      = 3;
  localparam int IDX_W      = 10;
  localparam int SIZE_W     = 11;
  localparam int STEP_W     = 24;
  localparam int KMAG_W     = 24;
  localparam int SAMP_W     = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // internal arithmetic widths
  localparam int KPROD_W    = SIZE_W + STEP_W;
  localparam int KSQ_W      = 2 * KMAG_W;
  localparam int SQ_W       = KSQ_W + 2;
  localparam int ROOT_W     = SQ_W / 2;
  localparam int RATIO_FRAC = 30;
  localparam int RATIO_W    = RATIO_FRAC + 1;
  localparam int INV_SHIFT  = 16;
  localparam int SQ_SHIFT   = 32;
  localparam int SQ_SPLIT   = ROOT_W;
  localparam int NUM_W      = 56;
  localparam int DEN_W      = ROOT_W;
  localparam int QUO_W      = 32;
  localparam int OMAG_W     = SAMP_W + 1;

  // pipeline shape of the iterative units
  localparam int SQRT_PER_STAGE = 5;
  localparam int SQRT_STAGES    = ROOT_W / SQRT_PER_STAGE;
  localparam int DIV_PER_STAGE  = 4;
  localparam int DIV_STAGES     = QUO_W / DIV_PER_STAGE;

  localparam logic [KMAG_W-1:0] KMAG_MAX = '1;

  // operation codes
  typedef enum logic [CMD_W-1:0] {
    CMD_DX  = 3'd0,
    CMD_DY  = 3'd1,
    CMD_DZ  = 3'd2,
    CMD_INV = 3'd3,
    CMD_SQ  = 3'd4
  } cmd_t;

endpackage

// ----- src/wdbm_sqrt_pipe.sv -----
// pipelined integer square root, five result bits per stage
`timescale 1ns / 1ps

module wdbm_sqrt_pipe (
  input  logic                        clk,
  input  logic [wdbm_pkg::SQ_W-1:0]   radicand,
  output logic [wdbm_pkg::ROOT_W-1:0] root
);

  localparam int VW = wdbm_pkg::SQ_W + 1;
  localparam int NS = wdbm_pkg::SQRT_STAGES;
  localparam int PS = wdbm_pkg::SQRT_PER_STAGE;

  logic [VW-1:0] rem_q [NS];
  logic [VW-1:0] res_q [NS];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic [VW-1:0] rem_in, res_in, rem_c, res_c;

    if (s == 0) begin : g_first
      assign rem_in = VW'(radicand);
      assign res_in = '0;
    end else begin : g_rest
      assign rem_in = rem_q[s-1];
      assign res_in = res_q[s-1];
    end

    // digit-by-digit root steps of this stage
    always_comb begin
      logic [VW-1:0] trial;
      logic [VW-1:0] b;
      rem_c = rem_in;
      res_c = res_in;
      for (int k = 0; k < PS; k++) begin
        b = VW'(1) << (2 * (wdbm_pkg::ROOT_W - 1 - (s * PS + k)));
        trial = res_c + b;
        if (rem_c >= trial) begin
          rem_c = rem_c - trial;
          res_c = (res_c >> 1) + b;
        end else begin
          res_c = res_c >> 1;
        end
      end
    end

    always_ff @(posedge clk) begin
      rem_q[s] <= rem_c;
      res_q[s] <= res_c;
    end
  end

  assign root = res_q[NS-1][wdbm_pkg::ROOT_W-1:0];

endmodule

// ----- src/wdbm_div_pipe.sv -----
// pipelined restoring divider with a quotient overflow flag
`timescale 1ns / 1ps

module wdbm_div_pipe (
  input  logic                       clk,
  input  logic [wdbm_pkg::NUM_W-1:0] dividend,
  input  logic [wdbm_pkg::DEN_W-1:0] divisor,
  output logic [wdbm_pkg::QUO_W-1:0] quotient,
  output logic                       overflow
);

  localparam int NS = wdbm_pkg::DIV_STAGES;
  localparam int PS = wdbm_pkg::DIV_PER_STAGE;
  localparam int QW = wdbm_pkg::QUO_W;
  localparam int DW = wdbm_pkg::DEN_W;
  localparam int NW = wdbm_pkg::NUM_W;

  logic [DW-1:0] rem_q [NS];
  logic [QW-1:0] low_q [NS];
  logic [QW-1:0] quo_q [NS];
  logic [DW-1:0] den_q [NS];
  logic          ovf_q [NS];

  // quotient at or above 2^QW when the top part already reaches the divisor
  logic          ovf_in;
  assign ovf_in = DW'(dividend[NW-1:QW]) >= divisor;

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic [DW-1:0] rem_in, rem_c, den_in;
    logic [QW-1:0] low_in, low_c, quo_in, quo_c;
    logic          ovf_s;

    if (s == 0) begin : g_first
      assign rem_in = ovf_in ? '0 : DW'(dividend[NW-1:QW]);
      assign low_in = dividend[QW-1:0];
      assign quo_in = '0;
      assign den_in = divisor;
      assign ovf_s  = ovf_in;
    end else begin : g_rest
      assign rem_in = rem_q[s-1];
      assign low_in = low_q[s-1];
      assign quo_in = quo_q[s-1];
      assign den_in = den_q[s-1];
      assign ovf_s  = ovf_q[s-1];
    end

    // one quotient bit per step
    always_comb begin
      logic [DW:0] t;
      rem_c = rem_in;
      low_c = low_in;
      quo_c = quo_in;
      for (int k = 0; k < PS; k++) begin
        t = {rem_c, low_c[QW-1]};
        low_c = low_c << 1;
        if (t >= {1'b0, den_in}) begin
          rem_c = DW'(t - {1'b0, den_in});
          quo_c = {quo_c[QW-2:0], 1'b1};
        end else begin
          rem_c = t[DW-1:0];
          quo_c = {quo_c[QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      rem_q[s] <= rem_c;
      low_q[s] <= low_c;
      quo_q[s] <= quo_c;
      den_q[s] <= den_in;
      ovf_q[s] <= ovf_s;
    end
  end

  assign quotient = quo_q[NS-1];
  assign overflow = ovf_q[NS-1];

endmodule

// ----- src/wavenumber_domain_bin_multiplier.sv -----
// top level: wavenumber bin multiplier pipeline and its configuration registers
`timescale 1ns / 1ps

// Takes one complex bin per clock whenever start is high; busy never rises, so a
// new word may follow in every cycle. Each word comes back on real_out, imag_out
// and saturated exactly 22 cycles after it was taken, marked by a one-cycle done
// pulse, and the receiver must take it then. The latency is set by the 5-stage
// square root of |k|^2 and the 8-stage 32-bit divider that follow the wavenumber
// and squaring stages. Configuration writes go in while no word is in flight.
module wavenumber_domain_bin_multiplier (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [wdbm_pkg::CMD_W-1:0]          cmd,
  input  logic [wdbm_pkg::IDX_W-1:0]          index_x,
  input  logic [wdbm_pkg::IDX_W-1:0]          index_y,
  input  logic [wdbm_pkg::IDX_W-1:0]          index_z,
  input  logic signed [wdbm_pkg::SAMP_W-1:0]  real_in,
  input  logic signed [wdbm_pkg::SAMP_W-1:0]  imag_in,
  output logic                                done,
  output logic signed [wdbm_pkg::SAMP_W-1:0]  real_out,
  output logic signed [wdbm_pkg::SAMP_W-1:0]  imag_out,
  output logic                                saturated,
  input  logic                                cfg_we,
  input  logic [wdbm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [wdbm_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int SZW = wdbm_pkg::SIZE_W;
  localparam int STW = wdbm_pkg::STEP_W;
  localparam int KW  = wdbm_pkg::KMAG_W;
  localparam int SW  = wdbm_pkg::SAMP_W;
  localparam int QW  = wdbm_pkg::SQ_W;
  localparam int RW  = wdbm_pkg::ROOT_W;
  localparam int NW  = wdbm_pkg::NUM_W;
  localparam int DW  = wdbm_pkg::DEN_W;
  localparam int OW  = wdbm_pkg::OMAG_W;
  localparam int RTW = wdbm_pkg::RATIO_W;
  localparam int SPL = wdbm_pkg::SQ_SPLIT;
  localparam int PLW = SPL + SW;
  localparam int PRW = RTW + SW;
  localparam int TTW = PLW + SPL + 1;
  localparam int NSQ = wdbm_pkg::SQRT_STAGES;
  localparam int NDV = wdbm_pkg::DIV_STAGES;
  localparam logic [OW-1:0] POS_LIM = OW'((64'd1 << (SW - 1)) - 64'd1);
  localparam logic [OW-1:0] NEG_LIM = OW'(64'd1 << (SW - 1));

  typedef enum logic [wdbm_pkg::CFG_IDX_W-1:0] {
    REG_SIZE_X  = 3'd0,
    REG_SIZE_Y  = 3'd1,
    REG_SIZE_Z  = 3'd2,
    REG_STEP_KX = 3'd3,
    REG_STEP_KY = 3'd4,
    REG_STEP_KZ = 3'd5,
    REG_FLOOR_K = 3'd6
  } cfg_reg_t;

  // word state carried alongside the root and divider pipelines
  typedef struct packed {
    logic                 valid;
    wdbm_pkg::cmd_t       cmd;
    logic [KW-1:0]        ka;
    logic                 kn;
    logic [SW-1:0]        re_mag;
    logic [SW-1:0]        im_mag;
    logic                 nre;
    logic                 nim;
    logic [QW-1:0]        sq;
    logic                 kk_zero;
  } side_t;

  // signed distance of an index from the origin of its axis, as sign and size
  function automatic logic [SZW:0] wave_offset(input logic [SZW-1:0] i,
                                               input logic [SZW-1:0] n);
    logic [SZW:0] r;
    if (i <= (n >> 1)) begin
      r = {1'b1, i};
    end else if (i < n) begin
      r = {1'b0, n - i};
    end else begin
      r = {1'b1, i - n};
    end
    return r;
  endfunction

  // configuration registers
  logic [SZW-1:0] size_x, size_y, size_z;
  logic [STW-1:0] step_kx, step_ky, step_kz, floor_k;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_x  <= SZW'(1);
      size_y  <= SZW'(1);
      size_z  <= SZW'(2);
      step_kx <= '0;
      step_ky <= '0;
      step_kz <= '0;
      floor_k <= STW'(1);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SIZE_X:  size_x  <= cfg_data[SZW-1:0];
        REG_SIZE_Y:  size_y  <= cfg_data[SZW-1:0];
        REG_SIZE_Z:  size_z  <= cfg_data[SZW-1:0];
        REG_STEP_KX: step_kx <= cfg_data[STW-1:0];
        REG_STEP_KY: step_ky <= cfg_data[STW-1:0];
        REG_STEP_KZ: step_kz <= cfg_data[STW-1:0];
        REG_FLOOR_K: floor_k <= cfg_data[STW-1:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // stage 1: capture the word
  logic                   p1_valid;
  wdbm_pkg::cmd_t         p1_cmd;
  logic [SZW-1:0]         p1_ix, p1_iy, p1_iz;
  logic [SW-1:0]          p1_re, p1_im;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else begin
      p1_valid <= start && !busy;
    end
    p1_cmd <= wdbm_pkg::cmd_t'(cmd);
    p1_ix  <= SZW'(index_x);
    p1_iy  <= SZW'(index_y);
    p1_iz  <= SZW'(index_z);
    p1_re  <= real_in;
    p1_im  <= imag_in;
  end

  // stage 2: axis offsets and sample magnitudes
  logic                   p2_valid;
  wdbm_pkg::cmd_t         p2_cmd;
  logic [SZW:0]           p2_ox, p2_oy, p2_oz;
  logic [SW-1:0]          p2_re_mag, p2_im_mag;
  logic                   p2_nre, p2_nim;

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_valid <= 1'b0;
    end else begin
      p2_valid <= p1_valid;
    end
    p2_cmd    <= p1_cmd;
    p2_ox     <= wave_offset(p1_ix, size_x);
    p2_oy     <= wave_offset(p1_iy, size_y);
    p2_oz     <= wave_offset(p1_iz, size_z);
    p2_re_mag <= p1_re[SW-1] ? SW'(0) - p1_re : p1_re;
    p2_im_mag <= p1_im[SW-1] ? SW'(0) - p1_im : p1_im;
    p2_nre    <= p1_re[SW-1];
    p2_nim    <= p1_im[SW-1];
  end

  // stage 3: wavenumbers, magnitude clipped to the Q8.16 range
  logic [wdbm_pkg::KPROD_W-1:0] kpx, kpy, kpz;
  logic [KW-1:0]          kxm_c, kym_c, kzm_c;

  assign kpx   = p2_ox[SZW-1:0] * step_kx;
  assign kpy   = p2_oy[SZW-1:0] * step_ky;
  assign kpz   = p2_oz[SZW-1:0] * step_kz;
  assign kxm_c = (kpx > wdbm_pkg::KPROD_W'(wdbm_pkg::KMAG_MAX)) ?
                 wdbm_pkg::KMAG_MAX : kpx[KW-1:0];
  assign kym_c = (kpy > wdbm_pkg::KPROD_W'(wdbm_pkg::KMAG_MAX)) ?
                 wdbm_pkg::KMAG_MAX : kpy[KW-1:0];
  assign kzm_c = (kpz > wdbm_pkg::KPROD_W'(wdbm_pkg::KMAG_MAX)) ?
                 wdbm_pkg::KMAG_MAX : kpz[KW-1:0];

  logic                   p3_valid;
  wdbm_pkg::cmd_t         p3_cmd;
  logic [KW-1:0]          p3_kxm, p3_kym, p3_kzm;
  logic                   p3_nx, p3_ny, p3_nz;
  logic [SW-1:0]          p3_re_mag, p3_im_mag;
  logic                   p3_nre, p3_nim;

  always_ff @(posedge clk) begin
    if (rst) begin
      p3_valid <= 1'b0;
    end else begin
      p3_valid <= p2_valid;
    end
    p3_cmd    <= p2_cmd;
    p3_kxm    <= kxm_c;
    p3_kym    <= kym_c;
    p3_kzm    <= kzm_c;
    p3_nx     <= p2_ox[SZW] && (kxm_c != '0);
    p3_ny     <= p2_oy[SZW] && (kym_c != '0);
    p3_nz     <= p2_oz[SZW] && (kzm_c != '0);
    p3_re_mag <= p2_re_mag;
    p3_im_mag <= p2_im_mag;
    p3_nre    <= p2_nre;
    p3_nim    <= p2_nim;
  end

  // stage 4: squares, and the axis that a derivative works on
  logic [KW-1:0]          ka_c;
  logic                   kn_c;

  always_comb begin
    case (p3_cmd)
      wdbm_pkg::CMD_DX: begin
        ka_c = p3_kxm;
        kn_c = p3_nx;
      end
      wdbm_pkg::CMD_DY: begin
        ka_c = p3_kym;
        kn_c = p3_ny;
      end
      default: begin
        ka_c = p3_kzm;
        kn_c = p3_nz;
      end
    endcase
  end

  logic                   p4_valid;
  wdbm_pkg::cmd_t         p4_cmd;
  logic [wdbm_pkg::KSQ_W-1:0] p4_sqx, p4_sqy, p4_sqz;
  logic [KW-1:0]          p4_ka;
  logic                   p4_kn;
  logic [SW-1:0]          p4_re_mag, p4_im_mag;
  logic                   p4_nre, p4_nim;

  always_ff @(posedge clk) begin
    if (rst) begin
      p4_valid <= 1'b0;
    end else begin
      p4_valid <= p3_valid;
    end
    p4_cmd    <= p3_cmd;
    p4_sqx    <= p3_kxm * p3_kxm;
    p4_sqy    <= p3_kym * p3_kym;
    p4_sqz    <= p3_kzm * p3_kzm;
    p4_ka     <= ka_c;
    p4_kn     <= kn_c;
    p4_re_mag <= p3_re_mag;
    p4_im_mag <= p3_im_mag;
    p4_nre    <= p3_nre;
    p4_nim    <= p3_nim;
  end

  // stage 5: |k|^2
  side_t                  p5;

  always_ff @(posedge clk) begin
    if (rst) begin
      p5.valid <= 1'b0;
    end else begin
      p5.valid <= p4_valid;
    end
    p5.cmd     <= p4_cmd;
    p5.ka      <= p4_ka;
    p5.kn      <= p4_kn;
    p5.re_mag  <= p4_re_mag;
    p5.im_mag  <= p4_im_mag;
    p5.nre     <= p4_nre;
    p5.nim     <= p4_nim;
    p5.sq      <= QW'(p4_sqx) + QW'(p4_sqy) + QW'(p4_sqz);
    p5.kk_zero <= 1'b0;
  end

  // |k| from the root pipeline, word state delayed to match
  logic [RW-1:0]          kk;
  side_t                  sd_sq [NSQ];

  wdbm_sqrt_pipe u_sqrt (
    .clk      (clk),
    .radicand (p5.sq),
    .root     (kk)
  );

  always_ff @(posedge clk) begin
    for (int s = 0; s < NSQ; s++) begin
      if (rst) begin
        sd_sq[s] <= '0;
      end else if (s == 0) begin
        sd_sq[s] <= p5;
      end else begin
        sd_sq[s] <= sd_sq[s-1];
      end
    end
  end

  // stage 6: dividends and divisors for the ratio or the inverse filter
  side_t                  sq_out;
  side_t                  p6_next;
  logic [DW-1:0]          floor_eff, den_inv;
  logic                   is_deriv;

  assign sq_out    = sd_sq[NSQ-1];
  assign floor_eff = (floor_k == '0) ? DW'(1) : DW'(floor_k);
  assign den_inv   = (kk < floor_eff) ? floor_eff : kk;
  assign is_deriv  = (sq_out.cmd == wdbm_pkg::CMD_DX) || (sq_out.cmd == wdbm_pkg::CMD_DY) ||
                     (sq_out.cmd == wdbm_pkg::CMD_DZ);

  always_comb begin
    p6_next         = sq_out;
    p6_next.kk_zero = (kk == '0);
  end

  side_t                  p6;
  logic [NW-1:0]          p6_num0, p6_num1;
  logic [DW-1:0]          p6_den0, p6_den1;

  always_ff @(posedge clk) begin
    if (rst) begin
      p6 <= '0;
    end else begin
      p6 <= p6_next;
    end
    if (is_deriv) begin
      p6_num0 <= (NW'(sq_out.ka) << wdbm_pkg::RATIO_FRAC) + NW'(kk >> 1);
      p6_den0 <= kk;
    end else begin
      p6_num0 <= (NW'(sq_out.re_mag) << wdbm_pkg::INV_SHIFT) + NW'(den_inv >> 1);
      p6_den0 <= den_inv;
    end
    p6_num1 <= (NW'(sq_out.im_mag) << wdbm_pkg::INV_SHIFT) + NW'(den_inv >> 1);
    p6_den1 <= den_inv;
  end

  // two divider lanes, word state delayed to match
  logic [wdbm_pkg::QUO_W-1:0] q0, q1;
  logic                   ovf0, ovf1;
  side_t                  sd_dv [NDV];

  wdbm_div_pipe u_div0 (
    .clk      (clk),
    .dividend (p6_num0),
    .divisor  (p6_den0),
    .quotient (q0),
    .overflow (ovf0)
  );

  wdbm_div_pipe u_div1 (
    .clk      (clk),
    .dividend (p6_num1),
    .divisor  (p6_den1),
    .quotient (q1),
    .overflow (ovf1)
  );

  always_ff @(posedge clk) begin
    for (int s = 0; s < NDV; s++) begin
      if (rst) begin
        sd_dv[s] <= '0;
      end else if (s == 0) begin
        sd_dv[s] <= p6;
      end else begin
        sd_dv[s] <= sd_dv[s-1];
      end
    end
  end

  // stage 7: products for the derivative and squared filters
  side_t                  dv_out;
  assign dv_out = sd_dv[NDV-1];

  side_t                  p7;
  logic [wdbm_pkg::QUO_W-1:0] p7_q0, p7_q1;
  logic                   p7_ovf0, p7_ovf1;
  logic [PRW-1:0]         p7_pd_re, p7_pd_im;
  logic [PLW-1:0]         p7_pl_re, p7_ph_re, p7_pl_im, p7_ph_im;

  always_ff @(posedge clk) begin
    if (rst) begin
      p7 <= '0;
    end else begin
      p7 <= dv_out;
    end
    p7_q0    <= q0;
    p7_q1    <= q1;
    p7_ovf0  <= ovf0;
    p7_ovf1  <= ovf1;
    p7_pd_re <= q0[RTW-1:0] * dv_out.im_mag;
    p7_pd_im <= q0[RTW-1:0] * dv_out.re_mag;
    p7_pl_re <= dv_out.sq[SPL-1:0] * dv_out.re_mag;
    p7_ph_re <= dv_out.sq[QW-1:SPL] * dv_out.re_mag;
    p7_pl_im <= dv_out.sq[SPL-1:0] * dv_out.im_mag;
    p7_ph_im <= dv_out.sq[QW-1:SPL] * dv_out.im_mag;
  end

  // stage 8: rounding, filter select and result signs
  logic [PRW:0]           rd_re, rd_im;
  logic [OW-1:0]          dmag_re, dmag_im;
  logic [TTW-1:0]         tot_re, tot_im;
  logic [TTW-wdbm_pkg::SQ_SHIFT-1:0] sqq_re, sqq_im;
  logic [OW-1:0]          smag_re, smag_im;
  logic [OW-1:0]          mag_re_c, mag_im_c;
  logic                   neg_re_c, neg_im_c;

  assign rd_re   = (PRW + 1)'(p7_pd_re) + ((PRW + 1)'(1) << (wdbm_pkg::RATIO_FRAC - 1));
  assign rd_im   = (PRW + 1)'(p7_pd_im) + ((PRW + 1)'(1) << (wdbm_pkg::RATIO_FRAC - 1));
  assign dmag_re = OW'(rd_re >> wdbm_pkg::RATIO_FRAC);
  assign dmag_im = OW'(rd_im >> wdbm_pkg::RATIO_FRAC);

  assign tot_re  = (TTW'(p7_ph_re) << SPL) + TTW'(p7_pl_re) +
                   (TTW'(1) << (wdbm_pkg::SQ_SHIFT - 1));
  assign tot_im  = (TTW'(p7_ph_im) << SPL) + TTW'(p7_pl_im) +
                   (TTW'(1) << (wdbm_pkg::SQ_SHIFT - 1));
  assign sqq_re  = tot_re[TTW-1:wdbm_pkg::SQ_SHIFT];
  assign sqq_im  = tot_im[TTW-1:wdbm_pkg::SQ_SHIFT];
  assign smag_re = (sqq_re[TTW-wdbm_pkg::SQ_SHIFT-1:OW] != '0) ? '1 : sqq_re[OW-1:0];
  assign smag_im = (sqq_im[TTW-wdbm_pkg::SQ_SHIFT-1:OW] != '0) ? '1 : sqq_im[OW-1:0];

  always_comb begin
    mag_re_c = '0;
    mag_im_c = '0;
    neg_re_c = 1'b0;
    neg_im_c = 1'b0;
    case (p7.cmd) inside
      wdbm_pkg::CMD_DX, wdbm_pkg::CMD_DY, wdbm_pkg::CMD_DZ: begin
        if (!p7.kk_zero) begin
          mag_re_c = dmag_re;
          mag_im_c = dmag_im;
          neg_re_c = (p7.kn == p7.nim) && (dmag_re != '0);
          neg_im_c = (p7.kn != p7.nre) && (dmag_im != '0);
        end
      end
      wdbm_pkg::CMD_INV: begin
        mag_re_c = p7_ovf0 ? '1 : OW'(p7_q0);
        mag_im_c = p7_ovf1 ? '1 : OW'(p7_q1);
        neg_re_c = p7.nre;
        neg_im_c = p7.nim;
      end
      wdbm_pkg::CMD_SQ: begin
        mag_re_c = smag_re;
        mag_im_c = smag_im;
        neg_re_c = p7.nre && (smag_re != '0);
        neg_im_c = p7.nim && (smag_im != '0);
      end
      default: ;
    endcase
  end

  logic                   p8_valid;
  logic [OW-1:0]          p8_mag_re, p8_mag_im;
  logic                   p8_neg_re, p8_neg_im;

  always_ff @(posedge clk) begin
    if (rst) begin
      p8_valid <= 1'b0;
    end else begin
      p8_valid <= p7.valid;
    end
    p8_mag_re <= mag_re_c;
    p8_mag_im <= mag_im_c;
    p8_neg_re <= neg_re_c;
    p8_neg_im <= neg_im_c;
  end

  // stage 9: saturate into the sample width and drive the result word
  logic [OW-1:0]          lim_re, lim_im, cl_re, cl_im;
  logic                   sat_re, sat_im;

  assign lim_re = p8_neg_re ? NEG_LIM : POS_LIM;
  assign lim_im = p8_neg_im ? NEG_LIM : POS_LIM;
  assign sat_re = p8_mag_re > lim_re;
  assign sat_im = p8_mag_im > lim_im;
  assign cl_re  = sat_re ? lim_re : p8_mag_re;
  assign cl_im  = sat_im ? lim_im : p8_mag_im;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= p8_valid;
    end
    real_out  <= p8_neg_re ? SW'(OW'(0) - cl_re) : cl_re[SW-1:0];
    imag_out  <= p8_neg_im ? SW'(OW'(0) - cl_im) : cl_im[SW-1:0];
    saturated <= sat_re || sat_im;
  end

endmodule

// ----- dv/tb_top.sv -----
// self-checking testbench for the wavenumber bin multiplier
`timescale 1ns / 1ps

// expected result of one bin
typedef struct {
  logic [31:0] re;
  logic [31:0] im;
  bit          sat;
} bin_result_t;

// bit-exact model of the multiplier with its own register copy
class bin_scoreboard;
  localparam longint unsigned KMAX    = 64'hFF_FFFF;
  localparam longint unsigned POS_LIM = 64'h7FFF_FFFF;
  localparam int              RFRAC   = 30;

  longint unsigned size_x, size_y, size_z, step_kx, step_ky, step_kz, floor_k;
  bin_result_t     expected_q[$];
  int              mismatches;

  function new();
    size_x = 1; size_y = 1; size_z = 2;
    step_kx = 0; step_ky = 0; step_kz = 0;
    floor_k = 1;
    mismatches = 0;
  endfunction

  function void set_reg(int idx, longint unsigned val);
    case (idx)
      0: size_x = val & 64'h7FF;
      1: size_y = val & 64'h7FF;
      2: size_z = val & 64'h7FF;
      3: step_kx = val & KMAX;
      4: step_ky = val & KMAX;
      5: step_kz = val & KMAX;
      6: floor_k = val & KMAX;
      default: ;
    endcase
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  // signed wavenumber from index, saturated magnitude
  function longint unsigned wavenum(longint unsigned i, longint unsigned n,
                                    longint unsigned dk, output bit neg);
    longint unsigned m;
    if (i <= n / 2) begin
      m = i * dk;
      neg = 1;
    end else if (i < n) begin
      m = (n - i) * dk;
      neg = 0;
    end else begin
      m = (i - n) * dk;
      neg = 1;
    end
    if (m > KMAX) m = KMAX;
    if (m == 0) neg = 0;
    return m;
  endfunction

  function longint unsigned root_floor(longint unsigned v);
    longint unsigned res, bt;
    res = 0;
    bt = 64'd1 << 62;
    while (bt > v) bt = bt >> 2;
    while (bt != 0) begin
      if (v >= res + bt) begin
        v = v - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  function longint unsigned sample_abs(logic [31:0] raw, output bit neg);
    neg = raw[31];
    if (raw[31]) return (64'd1 << 32) - {32'd0, raw};
    return {32'd0, raw};
  endfunction

  function logic [31:0] clip(longint unsigned mag, bit neg, inout bit sat);
    longint unsigned lim;
    lim = neg ? POS_LIM + 1 : POS_LIM;
    if (mag > lim) begin
      mag = lim;
      sat = 1;
    end
    if (neg) return 32'(64'd0 - mag);
    return 32'(mag);
  endfunction

  function longint unsigned scale_ratio(longint unsigned r, longint unsigned s);
    return (r * s + (64'd1 << (RFRAC - 1))) >> RFRAC;
  endfunction

  // round(s * sq / 2^32), clipped just above the limit
  function longint unsigned scale_ksq(longint unsigned sq, longint unsigned s);
    longint unsigned a, b, c, t, u, q;
    a = sq >> 32;
    b = (sq >> 16) & 64'hFFFF;
    c = sq & 64'hFFFF;
    t = c * s + (64'd1 << 31);
    u = b * s + (t >> 16);
    q = u >> 16;
    if (a != 0 && s > (POS_LIM + 1) / a) return POS_LIM + 2;
    return q + a * s;
  endfunction

  // note an accepted bin and queue its expected result
  function void note_word(logic [2:0] cmd, logic [9:0] ix, logic [9:0] iy,
                          logic [9:0] iz, logic [31:0] rin, logic [31:0] iin);
    bit nx, ny, nz, nre, nim, kn, rneg, ineg, sat;
    longint unsigned kxm, kym, kzm, re, im, sq, kk, ka, r, rm, imm, d, f;
    bin_result_t res;
    kxm = wavenum(64'(ix), size_x, step_kx, nx);
    kym = wavenum(64'(iy), size_y, step_ky, ny);
    kzm = wavenum(64'(iz), size_z, step_kz, nz);
    re = sample_abs(rin, nre);
    im = sample_abs(iin, nim);
    sq = kxm * kxm + kym * kym + kzm * kzm;
    kk = root_floor(sq);
    sat = 0;
    res.re = '0;
    res.im = '0;
    if (cmd == wdbm_pkg::CMD_DX || cmd == wdbm_pkg::CMD_DY || cmd == wdbm_pkg::CMD_DZ) begin
      ka = (cmd == wdbm_pkg::CMD_DX) ? kxm : (cmd == wdbm_pkg::CMD_DY) ? kym : kzm;
      kn = (cmd == wdbm_pkg::CMD_DX) ? nx : (cmd == wdbm_pkg::CMD_DY) ? ny : nz;
      if (kk != 0) begin
        r = ((ka << RFRAC) + kk / 2) / kk;
        rm = scale_ratio(r, im);
        imm = scale_ratio(r, re);
        rneg = (kn == nim);
        ineg = (kn != nre);
        if (rm == 0) rneg = 0;
        if (imm == 0) ineg = 0;
        res.re = clip(rm, rneg, sat);
        res.im = clip(imm, ineg, sat);
      end
    end else if (cmd == wdbm_pkg::CMD_INV) begin
      f = floor_k ? floor_k : 1;
      d = (kk < f) ? f : kk;
      res.re = clip(((re << 16) + d / 2) / d, nre, sat);
      res.im = clip(((im << 16) + d / 2) / d, nim, sat);
    end else if (cmd == wdbm_pkg::CMD_SQ) begin
      rm = scale_ksq(sq, re);
      imm = scale_ksq(sq, im);
      res.re = clip(rm, nre && rm != 0, sat);
      res.im = clip(imm, nim && imm != 0, sat);
    end
    res.sat = sat;
    expected_q.push_back(res);
  endfunction

  task report(string what);
    $display("mismatch at %0t: %s", $time, what);
    mismatches++;
  endtask

  // compare one result word with the oldest expectation
  task check_word(logic [31:0] re, logic [31:0] im, logic sat);
    bin_result_t e;
    if (expected_q.size() == 0) begin
      report("result word with nothing expected");
      return;
    end
    e = expected_q.pop_front();
    if (re !== e.re) report($sformatf("real_out %h, want %h", re, e.re));
    if (im !== e.im) report($sformatf("imag_out %h, want %h", im, e.im));
    if (sat !== e.sat) report($sformatf("saturated %b, want %b", sat, e.sat));
  endtask
endclass

module tb_top;

  localparam int REG_SIZE_X = 0;
  localparam int REG_SIZE_Y = 1;
  localparam int REG_SIZE_Z = 2;
  localparam int REG_STEP_KX = 3;
  localparam int REG_STEP_KY = 4;
  localparam int REG_STEP_KZ = 5;
  localparam int REG_FLOOR_K = 6;
  localparam int NUM_REGS = 7;
  localparam logic [2:0] CMD_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] CMD_UNUSED_LAST  = 3'd7;
  localparam int LATENCY = 22;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES = 8;
  localparam int PHASE_WORDS = 230;

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy;
  logic [wdbm_pkg::CMD_W-1:0] cmd = '0;
  logic [wdbm_pkg::IDX_W-1:0] index_x = '0, index_y = '0, index_z = '0;
  logic signed [wdbm_pkg::SAMP_W-1:0] real_in = '0, imag_in = '0;
  logic done;
  logic signed [wdbm_pkg::SAMP_W-1:0] real_out, imag_out;
  logic saturated;
  logic cfg_we = 0;
  logic [wdbm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [wdbm_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  bin_scoreboard sb = new();
  int cycles = 0;
  longint unsigned reg_val[NUM_REGS];

  wavenumber_domain_bin_multiplier u_dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && done) sb.check_word(real_out, imag_out, saturated);
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("** wavenumber_domain_bin_multiplier: FAILED **");
      $finish;
    end
  end

  // present one bin and hold it until taken
  task send_word(logic [2:0] c, logic [9:0] ix, logic [9:0] iy, logic [9:0] iz,
                 logic [31:0] re, logic [31:0] im);
    start <= 1;
    cmd <= c;
    index_x <= ix;
    index_y <= iy;
    index_z <= iz;
    real_in <= re;
    imag_in <= im;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_word(c, ix, iy, iz, re, im);
  endtask

  task drain();
    start <= 0;
    @(posedge clk);
    while (sb.pending() > 0) @(posedge clk);
  endtask

  // write all registers from reg_val while idle
  task write_regs();
    drain();
    repeat (LATENCY + 3) @(posedge clk);
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_we <= 1;
      cfg_index <= wdbm_pkg::CFG_IDX_W'(i);
      cfg_data <= wdbm_pkg::CFG_DATA_W'(reg_val[i]);
      sb.set_reg(i, reg_val[i]);
      @(posedge clk);
    end
    cfg_we <= 0;
  endtask

  task set_regs(longint unsigned sx, longint unsigned sy, longint unsigned sz,
                longint unsigned kx, longint unsigned ky, longint unsigned kz,
                longint unsigned fl);
    reg_val[REG_SIZE_X] = sx;
    reg_val[REG_SIZE_Y] = sy;
    reg_val[REG_SIZE_Z] = sz;
    reg_val[REG_STEP_KX] = kx;
    reg_val[REG_STEP_KY] = ky;
    reg_val[REG_STEP_KZ] = kz;
    reg_val[REG_FLOOR_K] = fl;
    write_regs();
  endtask

  function automatic longint unsigned rand_step();
    case ($urandom_range(0, 2))
      0: return 64'($urandom_range(0, 24'hFF_FFFF));
      1: return 64'($urandom_range(0, 24'h2_0000));
      default: return 64'($urandom_range(0, 24'h800));
    endcase
  endfunction

  // mostly in-range indices, with the fold point and stray values mixed in
  function automatic logic [9:0] pick_index(longint unsigned n, bit half);
    int r;
    longint unsigned top;
    r = $urandom_range(0, 9);
    top = half ? n / 2 : (n > 0 ? n - 1 : 0);
    if (top > 1023) top = 1023;
    if (r < 7) return 10'($urandom_range(0, int'(top)));
    if (r == 7) begin
      case ($urandom_range(0, 3))
        0: return 10'd0;
        1: return 10'(n / 2);
        2: return 10'(n / 2 + 1);
        default: return 10'(n > 0 ? n - 1 : 0);
      endcase
    end
    return 10'($urandom_range(0, 1023));
  endfunction

  function automatic logic [31:0] pick_sample();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return $urandom;
      5, 6: begin
        v = $urandom_range(0, 32'h10_0000);
        return $urandom_range(0, 1) ? -v : v;
      end
      7: begin
        case ($urandom_range(0, 4))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'h0;
          3: return 32'h1;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default: begin
        v = $urandom_range(0, 32'h100_0000);
        return $urandom_range(0, 1) ? -v : v;
      end
    endcase
  endfunction

  // one stretch of random bins, optionally with idle bursts and a full pause
  task run_phase(int words, bit idle_on, bit pause_mid);
    logic [2:0] c;
    for (int i = 0; i < words; i++) begin
      if ($urandom_range(0, 19) == 0) begin
        c = 3'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST));
      end else begin
        c = 3'($urandom_range(wdbm_pkg::CMD_DX, wdbm_pkg::CMD_SQ));
      end
      send_word(c, pick_index(sb.size_x, 0), pick_index(sb.size_y, 0),
                pick_index(sb.size_z, 1), pick_sample(), pick_sample());
      if (pause_mid && i == words / 2) begin
        drain();
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        start <= 0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed bins
    set_regs(16, 16, 16, 24'h1_0000, 24'h8000, 24'h4000, 24'h2_0000);
    send_word(wdbm_pkg::CMD_DX, 10'd3, 10'd5, 10'd2, 32'h0001_0000, 32'hFFFF_0000);
    send_word(wdbm_pkg::CMD_DY, 10'd3, 10'd5, 10'd2, 32'h7FFF_FFFF, 32'h8000_0000);
    send_word(wdbm_pkg::CMD_DZ, 10'd3, 10'd5, 10'd2, 32'h8000_0000, 32'h7FFF_FFFF);
    send_word(wdbm_pkg::CMD_INV, 10'd3, 10'd5, 10'd2, 32'h7FFF_FFFF, 32'h8000_0000);
    send_word(wdbm_pkg::CMD_SQ, 10'd3, 10'd5, 10'd2, 32'h7FFF_FFFF, 32'h8000_0000);
    send_word(CMD_UNUSED_FIRST, 10'd3, 10'd5, 10'd2, 32'h1234_5678, 32'h8765_4321);
    send_word(CMD_UNUSED_LAST, 10'd3, 10'd5, 10'd2, 32'hFFFF_FFFF, 32'h1);
    // zero |k| on derivatives and the floor on the inverse
    send_word(wdbm_pkg::CMD_DX, 10'd0, 10'd0, 10'd0, 32'h0001_0000, 32'h0002_0000);
    send_word(wdbm_pkg::CMD_DZ, 10'd0, 10'd0, 10'd0, 32'h8000_0000, 32'h7FFF_FFFF);
    send_word(wdbm_pkg::CMD_INV, 10'd0, 10'd0, 10'd0, 32'h7FFF_FFFF, 32'h8000_0000);
    // fold point, last index, at and beyond the size
    send_word(wdbm_pkg::CMD_DX, 10'd8, 10'd9, 10'd8, 32'h0010_0000, 32'hFFF0_0000);
    send_word(wdbm_pkg::CMD_DY, 10'd15, 10'd16, 10'd9, 32'h0010_0000, 32'h0010_0000);
    send_word(wdbm_pkg::CMD_DX, 10'd1023, 10'd1023, 10'd1023, 32'h4000_0000,
              32'hC000_0000);
    send_word(wdbm_pkg::CMD_SQ, 10'd1023, 10'd1023, 10'd512, 32'h7FFF_FFFF,
              32'h8000_0000);
    send_word(wdbm_pkg::CMD_SQ, 10'd1, 10'd0, 10'd0, 32'h0, 32'hFFFF_FFFF);
    send_word(wdbm_pkg::CMD_INV, 10'd512, 10'd1023, 10'd512, 32'h1, 32'hFFFF_FFFF);
    // wavenumber saturation, zero floor and a zero size
    set_regs(0, 1024, 1024, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 0);
    send_word(wdbm_pkg::CMD_DX, 10'd0, 10'd0, 10'd0, 32'h7FFF_FFFF, 32'h8000_0000);
    send_word(wdbm_pkg::CMD_INV, 10'd0, 10'd0, 10'd0, 32'h0000_8000, 32'hFFFF_8000);
    send_word(wdbm_pkg::CMD_DX, 10'd5, 10'd700, 10'd512, 32'h7FFF_FFFF, 32'h8000_0000);
    send_word(wdbm_pkg::CMD_SQ, 10'd5, 10'd700, 10'd512, 32'h1, 32'hFFFF_FFFF);
    send_word(wdbm_pkg::CMD_INV, 10'd5, 10'd700, 10'd512, 32'h7FFF_FFFF, 32'h8000_0000);

    // random phases over several register settings
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: set_regs(16, 16, 16, 24'h4000, 24'h4000, 24'h4000, 24'h800);
        1: set_regs(1024, 1024, 1024, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF);
        2: set_regs(1, 1, 2, 0, 0, 0, 1);
        3: set_regs(0, 5, 3, 24'h1_0000, 24'h2_0000, 24'h3_0000, 0);
        default: set_regs(64'($urandom_range(1, 1024)), 64'($urandom_range(1, 1024)),
                          64'($urandom_range(2, 1024)), rand_step(), rand_step(),
                          rand_step(),
                          $urandom_range(0, 1) ? 64'($urandom_range(1, 24'hFF_FFFF))
                                               : 64'($urandom_range(1, 24'h2_0000)));
      endcase
      run_phase(PHASE_WORDS, p < PHASES - 1, p == 3);
    end

    drain();
    repeat (LATENCY + 8) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("** wavenumber_domain_bin_multiplier: PASSED **");
    end else begin
      $display("** wavenumber_domain_bin_multiplier: FAILED **");
    end
    $finish;
  end
endmodule
